[rtl/plid_pkg.sv]
// Shared types and constants for the positional list block.
package plid_pkg;

    // Fixed field widths of the channels
    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int POSN_W   = 4;
    localparam int COUNT_W  = 5;

    // Defaults for the top-level parameters
    localparam int DEF_CAPACITY    = 16;
    localparam int DEF_ENTRY_WIDTH = 32;

    // Request modes
    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT   = 3'd0,
        MODE_DELETE   = 3'd1,
        MODE_COUNT    = 3'd2,
        MODE_LIST_FWD = 3'd3,
        MODE_LIST_REV = 3'd4
    } t_mode;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_BAD_POS = 2'd3
    } t_status;

    // Control FSM states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_LIST = 1'b1
    } t_state;

    // Operation broadcast to every cell of the row
    typedef enum logic [2:0] {
        OP_HOLD     = 3'd0,
        OP_INSERT   = 3'd1,
        OP_DELETE   = 3'd2,
        OP_ROT_DOWN = 3'd3,
        OP_ROT_UP   = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [POS_W-1:0]  pos;
    } t_cell_ctl;

endpackage

[rtl/plid_if.sv]
// Valid/ready channel interfaces for request and result beats.
interface plid_in_if;
    logic                         valid;
    logic                         ready;
    logic [plid_pkg::MODE_W-1:0]  mode;
    logic [plid_pkg::VALUE_W-1:0] entry_value;
    logic [plid_pkg::POS_W-1:0]   position;

    modport source (output valid, output mode, output entry_value, output position,
                    input ready);
    modport sink   (input valid, input mode, input entry_value, input position,
                    output ready);
endinterface

interface plid_out_if;
    logic                          valid;
    logic                          ready;
    logic [plid_pkg::STATUS_W-1:0] status;
    logic [plid_pkg::VALUE_W-1:0]  entry_value_res;
    logic [plid_pkg::POSN_W-1:0]   entry_position;
    logic [plid_pkg::COUNT_W-1:0]  entry_count;
    logic                          last;

    modport source (output valid, output status, output entry_value_res,
                    output entry_position, output entry_count, output last,
                    input ready);
    modport sink   (input valid, input status, input entry_value_res,
                    input entry_position, input entry_count, input last,
                    output ready);
endinterface

[rtl/plid_cell.sv]
// One list slot: holds an entry and takes it from itself, a neighbor, the wrap tap or the bus.
module plid_cell #(
    parameter int ENTRY_WIDTH = plid_pkg::DEF_ENTRY_WIDTH,
    parameter int IDX_W       = 4,
    parameter int CELL_IDX    = 0
) (
    input  logic                    i_clk,
    input  plid_pkg::t_cell_ctl     i_ctl,
    input  logic [IDX_W-1:0]        i_last_idx,
    input  logic [ENTRY_WIDTH-1:0]  i_value,
    input  logic [ENTRY_WIDTH-1:0]  i_wrap,
    input  logic [ENTRY_WIDTH-1:0]  i_left,
    input  logic [ENTRY_WIDTH-1:0]  i_right,
    output logic [ENTRY_WIDTH-1:0]  o_data
);

    localparam int CW = (IDX_W > plid_pkg::POS_W) ? IDX_W : plid_pkg::POS_W;
    localparam logic [CW-1:0] MY_IDX = CW'(CELL_IDX);

    logic [ENTRY_WIDTH-1:0] r_data;
    logic [ENTRY_WIDTH-1:0] n_data;
    logic [CW-1:0]          w_pos;
    logic [CW-1:0]          w_tail;

    assign w_pos  = CW'(i_ctl.pos);
    assign w_tail = CW'(i_last_idx);

    // Select the source of this slot for the coming cycle
    always_comb begin
        n_data = r_data;
        unique case (i_ctl.op)
            plid_pkg::OP_INSERT: begin
                if (MY_IDX == w_pos) begin
                    n_data = i_value;
                end else if (MY_IDX > w_pos) begin
                    n_data = i_left;
                end
            end
            plid_pkg::OP_DELETE: begin
                if (MY_IDX >= w_pos) begin
                    n_data = i_right;
                end
            end
            plid_pkg::OP_ROT_DOWN: begin
                if (MY_IDX == w_tail) begin
                    n_data = i_wrap;
                end else if (MY_IDX < w_tail) begin
                    n_data = i_right;
                end
            end
            plid_pkg::OP_ROT_UP: begin
                if (MY_IDX == '0) begin
                    n_data = i_wrap;
                end else if (MY_IDX <= w_tail) begin
                    n_data = i_left;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[rtl/plid_chain.sv]
// Row of list cells with head and tail taps for read-out and rotation.
module plid_chain #(
    parameter int CAPACITY    = plid_pkg::DEF_CAPACITY,
    parameter int ENTRY_WIDTH = plid_pkg::DEF_ENTRY_WIDTH,
    parameter int IDX_W       = 4
) (
    input  logic                    i_clk,
    input  plid_pkg::t_cell_ctl     i_ctl,
    input  logic [IDX_W-1:0]        i_last_idx,
    input  logic [ENTRY_WIDTH-1:0]  i_value,
    output logic [ENTRY_WIDTH-1:0]  o_head,
    output logic [ENTRY_WIDTH-1:0]  o_tail
);

    logic [ENTRY_WIDTH-1:0] w_data [CAPACITY];
    logic [ENTRY_WIDTH-1:0] w_wrap;

    // Tail tap: entry at the last occupied slot
    assign o_tail = w_data[i_last_idx];
    assign o_head = w_data[0];

    // Rotation wraps the head to the tail going down, the tail to the head going up
    assign w_wrap = (i_ctl.op == plid_pkg::OP_ROT_UP) ? o_tail : o_head;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ENTRY_WIDTH-1:0] w_left;
        logic [ENTRY_WIDTH-1:0] w_right;

        if (g > 0) begin : g_left
            assign w_left = w_data[g-1];
        end else begin : g_left_edge
            assign w_left = '0;
        end

        if (g < CAPACITY - 1) begin : g_right
            assign w_right = w_data[g+1];
        end else begin : g_right_edge
            assign w_right = '0;
        end

        plid_cell #(
            .ENTRY_WIDTH (ENTRY_WIDTH),
            .IDX_W       (IDX_W),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (i_ctl),
            .i_last_idx (i_last_idx),
            .i_value    (i_value),
            .i_wrap     (w_wrap),
            .i_left     (w_left),
            .i_right    (w_right),
            .o_data     (w_data[g])
        );
    end

endmodule

[rtl/positional_list_insert_delete.sv]
// Top level of the bounded positional list: control FSM, result register, cell row.
//
//   channel  dir  beat contents
//   i_in     in   mode, entry_value, position
//   o_out    out  status, entry_value_res, entry_position, entry_count, last
//
// Insert and delete shift all cells at once; for insert, delete and count the
// result lands in the output register. A list request gives one beat per entry,
// the row rotating one slot per beat so the head (or tail) tap reads out the
// next entry; N entries leave the row as it was.
// Reset empties the list; no request is taken while a list read-out runs,
// and a stall on o_out holds both the result register and the rotation.
module positional_list_insert_delete #(
    parameter int CAPACITY    = plid_pkg::DEF_CAPACITY,
    parameter int ENTRY_WIDTH = plid_pkg::DEF_ENTRY_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    plid_in_if.sink          i_in,
    plid_out_if.source       o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = (CNT_W > plid_pkg::POS_W) ? CNT_W : plid_pkg::POS_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    plid_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_step,  n_step;
    logic              r_rev,   n_rev;

    logic                           r_out_valid, n_out_valid;
    plid_pkg::t_status              r_status,    n_status;
    logic [plid_pkg::VALUE_W-1:0]   r_value,     n_value;
    logic [plid_pkg::POSN_W-1:0]    r_posn,      n_posn;
    logic [plid_pkg::COUNT_W-1:0]   r_cnt,       n_cnt;
    logic                           r_last,      n_last;

    plid_pkg::t_cell_ctl     w_ctl;
    plid_pkg::t_mode         w_mode;
    logic                    w_out_free;
    logic                    w_accept;
    logic                    w_last_step;
    logic [CNT_W-1:0]        w_last_cnt;
    logic [CMP_W-1:0]        w_pos_c;
    logic [CMP_W-1:0]        w_cnt_c;
    logic [ENTRY_WIDTH-1:0]  w_head;
    logic [ENTRY_WIDTH-1:0]  w_tail;
    logic [ENTRY_WIDTH-1:0]  w_tap;
    logic [CNT_W-1:0]        w_rd_pos;

    // Handshake and decode
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == plid_pkg::S_IDLE) && w_out_free;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_mode      = plid_pkg::t_mode'(i_in.mode);
    assign w_pos_c     = CMP_W'(i_in.position);
    assign w_cnt_c     = CMP_W'(r_count);
    assign w_last_cnt  = r_count - CNT_W'(1);
    assign w_last_step = (r_step == w_last_cnt);
    assign w_tap       = r_rev ? w_tail : w_head;
    assign w_rd_pos    = r_rev ? (w_last_cnt - r_step) : r_step;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plid_pkg::S_IDLE: begin
                if (w_accept && r_count != '0 &&
                    (w_mode == plid_pkg::MODE_LIST_FWD ||
                     w_mode == plid_pkg::MODE_LIST_REV)) begin
                    n_state = plid_pkg::S_LIST;
                end
            end
            plid_pkg::S_LIST: begin
                if (w_out_free && w_last_step) begin
                    n_state = plid_pkg::S_IDLE;
                end
            end
            default: n_state = plid_pkg::S_IDLE;
        endcase
    end

    // Cell control, counters and result beat
    always_comb begin
        w_ctl       = '{op: plid_pkg::OP_HOLD, pos: i_in.position};
        n_count     = r_count;
        n_step      = r_step;
        n_rev       = r_rev;
        n_out_valid = r_out_valid && !o_out.ready;
        n_status    = r_status;
        n_value     = r_value;
        n_posn      = r_posn;
        n_cnt       = r_cnt;
        n_last      = r_last;

        unique case (r_state)
            plid_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_status    = plid_pkg::STAT_OK;
                    n_value     = '0;
                    n_posn      = '0;
                    n_cnt       = plid_pkg::COUNT_W'(r_count);
                    n_last      = 1'b1;
                    n_step      = '0;
                    n_rev       = (w_mode == plid_pkg::MODE_LIST_REV);
                    unique case (w_mode)
                        plid_pkg::MODE_INSERT: begin
                            if (r_count == CAP_CNT) begin
                                n_status = plid_pkg::STAT_FULL;
                            end else if (w_pos_c > w_cnt_c) begin
                                n_status = plid_pkg::STAT_BAD_POS;
                            end else begin
                                w_ctl.op = plid_pkg::OP_INSERT;
                                n_count  = r_count + CNT_W'(1);
                                n_cnt    = plid_pkg::COUNT_W'(n_count);
                            end
                        end
                        plid_pkg::MODE_DELETE: begin
                            if (r_count == '0) begin
                                n_status = plid_pkg::STAT_EMPTY;
                            end else if (w_pos_c >= w_cnt_c) begin
                                n_status = plid_pkg::STAT_BAD_POS;
                            end else begin
                                w_ctl.op = plid_pkg::OP_DELETE;
                                n_count  = w_last_cnt;
                                n_cnt    = plid_pkg::COUNT_W'(n_count);
                            end
                        end
                        plid_pkg::MODE_COUNT: begin
                            n_status = plid_pkg::STAT_OK;
                        end
                        plid_pkg::MODE_LIST_FWD,
                        plid_pkg::MODE_LIST_REV: begin
                            if (r_count == '0) begin
                                n_status = plid_pkg::STAT_EMPTY;
                            end else begin
                                // read-out beats follow from the list state
                                n_out_valid = 1'b0;
                            end
                        end
                        default: begin
                            // unknown mode: consumed without a result
                            n_out_valid = 1'b0;
                        end
                    endcase
                end
            end
            plid_pkg::S_LIST: begin
                if (w_out_free) begin
                    w_ctl.op    = r_rev ? plid_pkg::OP_ROT_UP : plid_pkg::OP_ROT_DOWN;
                    n_out_valid = 1'b1;
                    n_status    = plid_pkg::STAT_OK;
                    n_value     = plid_pkg::VALUE_W'(w_tap);
                    n_posn      = plid_pkg::POSN_W'(w_rd_pos);
                    n_cnt       = plid_pkg::COUNT_W'(r_count);
                    n_last      = w_last_step;
                    n_step      = r_step + CNT_W'(1);
                end
            end
            default: begin
                w_ctl.op = plid_pkg::OP_HOLD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plid_pkg::S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_rev       <= n_rev;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_value  <= n_value;
        r_posn   <= n_posn;
        r_cnt    <= n_cnt;
        r_last   <= n_last;
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_status;
    assign o_out.entry_value_res = r_value;
    assign o_out.entry_position  = r_posn;
    assign o_out.entry_count     = r_cnt;
    assign o_out.last            = r_last;

    // Entry row
    plid_chain #(
        .CAPACITY    (CAPACITY),
        .ENTRY_WIDTH (ENTRY_WIDTH),
        .IDX_W       (IDX_W)
    ) u_chain (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_last_idx (IDX_W'(w_last_cnt)),
        .i_value    (ENTRY_WIDTH'(i_in.entry_value)),
        .o_head     (w_head),
        .o_tail     (w_tail)
    );

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("entry count above capacity");

    a_list_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == plid_pkg::S_LIST |-> (r_step < r_count))
        else $error("read-out step beyond entry count");

    a_list_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == plid_pkg::S_LIST |=> r_count == $past(r_count))
        else $error("entry count changed during read-out");

    a_list_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plid_pkg::S_LIST && w_out_free && w_last_step)
        |=> (r_state == plid_pkg::S_IDLE && r_out_valid && r_last))
        else $error("read-out did not close with a last beat");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_mode == plid_pkg::MODE_INSERT && r_count != CAP_CNT &&
         w_pos_c <= w_cnt_c)
        |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("accepted insert did not grow the list");

endmodule

[bench/tb_top.sv]
// Self-checking bench for the positional list: valid/ready traffic checked against a shadow list.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = plid_pkg::DEF_CAPACITY;
    // Mode codes the block ignores
    localparam logic [plid_pkg::MODE_W-1:0] MODE_RESERVED_MIN = 3'd5;
    localparam logic [plid_pkg::MODE_W-1:0] MODE_RESERVED_MID = 3'd6;
    localparam logic [plid_pkg::MODE_W-1:0] MODE_RESERVED_MAX = 3'd7;
    localparam int POS_MAX      = (1 << plid_pkg::POS_W) - 1;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [plid_pkg::MODE_W-1:0]  mode;
        logic [plid_pkg::VALUE_W-1:0] value;
        logic [plid_pkg::POS_W-1:0]   pos;
    } t_request;

    typedef struct {
        plid_pkg::t_status             status;
        logic [plid_pkg::VALUE_W-1:0]  value;
        logic [plid_pkg::POSN_W-1:0]   posn;
        logic [plid_pkg::COUNT_W-1:0]  count;
        logic                          last;
    } t_result_beat;

    logic i_clk;
    logic i_rst_n = 1'b0;

    // Bench-side drive registers, known from time zero
    logic                         drv_valid = 1'b0;
    logic [plid_pkg::MODE_W-1:0]  drv_mode  = '0;
    logic [plid_pkg::VALUE_W-1:0] drv_value = '0;
    logic [plid_pkg::POS_W-1:0]   drv_pos   = '0;
    logic                         mon_ready = 1'b0;

    plid_in_if  in_ch ();
    plid_out_if out_ch ();

    assign in_ch.valid       = drv_valid;
    assign in_ch.mode        = drv_mode;
    assign in_ch.entry_value = drv_value;
    assign in_ch.position    = drv_pos;
    assign out_ch.ready      = mon_ready;

    positional_list_insert_delete u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_request     pending_requests[$];
    t_result_beat expected_beats[$];

    // Shadow list updated as requests are accepted
    logic [plid_pkg::VALUE_W-1:0] stored_entries [CAPACITY];
    int unsigned                  stored_len = 0;

    // Length the list will have once every queued request has run (shapes positions)
    int unsigned planned_len = 0;

    int  failures      = 0;
    int  hold_requests = 0;
    int  holds_done    = 0;
    bit  quiet_tail    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Work out the result beats of one accepted request and advance the shadow list
    task automatic apply_request(input logic [plid_pkg::MODE_W-1:0] mode,
                                 input logic [plid_pkg::VALUE_W-1:0] value,
                                 input logic [plid_pkg::POS_W-1:0] pos);
        t_result_beat beat;
        int unsigned  n;
        int unsigned  idx;
        n = stored_len;
        beat = '{status: plid_pkg::STAT_OK, value: '0, posn: '0,
                 count: plid_pkg::COUNT_W'(n), last: 1'b1};
        case (mode)
            plid_pkg::MODE_INSERT: begin
                if (n >= CAPACITY) begin
                    beat.status = plid_pkg::STAT_FULL;
                end else if (pos > n) begin
                    beat.status = plid_pkg::STAT_BAD_POS;
                end else begin
                    for (int i = n; i > pos; i--) stored_entries[i] = stored_entries[i-1];
                    stored_entries[pos] = value;
                    stored_len = n + 1;
                    beat.count = plid_pkg::COUNT_W'(n + 1);
                end
                expected_beats.push_back(beat);
            end
            plid_pkg::MODE_DELETE: begin
                if (n == 0) begin
                    beat.status = plid_pkg::STAT_EMPTY;
                end else if (pos >= n) begin
                    beat.status = plid_pkg::STAT_BAD_POS;
                end else begin
                    for (int i = pos; i + 1 < n; i++) stored_entries[i] = stored_entries[i+1];
                    stored_len = n - 1;
                    beat.count = plid_pkg::COUNT_W'(n - 1);
                end
                expected_beats.push_back(beat);
            end
            plid_pkg::MODE_COUNT: begin
                expected_beats.push_back(beat);
            end
            plid_pkg::MODE_LIST_FWD, plid_pkg::MODE_LIST_REV: begin
                if (n == 0) begin
                    beat.status = plid_pkg::STAT_EMPTY;
                    expected_beats.push_back(beat);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        idx = (mode == plid_pkg::MODE_LIST_FWD) ? i : n - 1 - i;
                        beat.value = stored_entries[idx];
                        beat.posn  = plid_pkg::POSN_W'(idx);
                        beat.last  = (i + 1 == n);
                        expected_beats.push_back(beat);
                    end
                end
            end
            default: ;  // reserved modes produce nothing
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    // Driver: presents queued requests, with random gap bursts
    always @(posedge i_clk) begin : driver
        int       send_gap;
        t_request req;
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (drv_valid && in_ch.ready) apply_request(drv_mode, drv_value, drv_pos);
            if (drv_valid && !in_ch.ready) begin
                // beat held until taken
            end else if (send_gap != 0) begin
                drv_valid <= 1'b0;
                send_gap--;
            end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
                drv_valid <= 1'b0;
                send_gap = $urandom_range(0, 18);
            end else if (pending_requests.size() != 0) begin
                req = pending_requests.pop_front();
                drv_valid <= 1'b1;
                drv_mode  <= req.mode;
                drv_value <= req.value;
                drv_pos   <= req.pos;
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks result beats in order, stalls at random or for a long hold
    always @(posedge i_clk) begin : monitor
        int           stall_left;
        t_result_beat want;
        if (!i_rst_n) begin
            mon_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_ch.valid && mon_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("unexpected result beat: status %0d value %0h count %0d",
                           out_ch.status, out_ch.entry_value_res, out_ch.entry_count);
                    failures++;
                end else begin
                    want = expected_beats.pop_front();
                    check_field("status", want.status, out_ch.status);
                    check_field("entry_value_res", want.value, out_ch.entry_value_res);
                    check_field("entry_position", want.posn, out_ch.entry_position);
                    check_field("entry_count", want.count, out_ch.entry_count);
                    check_field("last", want.last, out_ch.last);
                end
            end
            if (holds_done != hold_requests) begin
                holds_done <= holds_done + 1;
                stall_left = LONG_HOLD;
                mon_ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                mon_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 18);
                mon_ready <= 1'b0;
            end else begin
                mon_ready <= 1'b1;
            end
        end
    end

    function automatic logic [plid_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_request(input logic [plid_pkg::MODE_W-1:0] m,
                                 input logic [plid_pkg::VALUE_W-1:0] v,
                                 input logic [plid_pkg::POS_W-1:0] p);
        t_request req;
        req = '{mode: m, value: v, pos: p};
        pending_requests.push_back(req);
        if (m == plid_pkg::MODE_INSERT && planned_len < CAPACITY && p <= planned_len)
            planned_len++;
        else if (m == plid_pkg::MODE_DELETE && planned_len != 0 && p < planned_len)
            planned_len--;
    endtask

    // Random request, mostly with a position that lands inside the list
    task automatic queue_random(input int ins_pct, input int del_pct);
        int                          r;
        logic [plid_pkg::MODE_W-1:0] m;
        logic [plid_pkg::POS_W-1:0]  p;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            m = plid_pkg::MODE_INSERT;
        else if (r < ins_pct + del_pct)
            m = plid_pkg::MODE_DELETE;
        else if (r < 95)
            m = plid_pkg::MODE_W'($urandom_range(int'(plid_pkg::MODE_COUNT),
                                                 int'(plid_pkg::MODE_LIST_REV)));
        else
            m = plid_pkg::MODE_W'($urandom_range(int'(MODE_RESERVED_MIN),
                                                 int'(MODE_RESERVED_MAX)));
        p = plid_pkg::POS_W'($urandom_range(0, POS_MAX));
        if ($urandom_range(0, 4) != 0) begin
            if (m == plid_pkg::MODE_INSERT)
                p = plid_pkg::POS_W'($urandom_range(0, planned_len));
            else if (m == plid_pkg::MODE_DELETE && planned_len != 0)
                p = plid_pkg::POS_W'($urandom_range(0, planned_len - 1));
        end
        queue_request(m, pick_value(), p);
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || drv_valid || expected_beats.size() != 0)
            @(negedge i_clk);
    endtask

    // Stimulus plan
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty list, shifts at head, middle and tail, bad positions, reserved modes
        queue_request(plid_pkg::MODE_LIST_FWD, '0, '0);
        queue_request(plid_pkg::MODE_LIST_REV, '0, '0);
        queue_request(plid_pkg::MODE_DELETE, '0, '0);
        queue_request(plid_pkg::MODE_DELETE, '0, plid_pkg::POS_W'(POS_MAX));
        queue_request(plid_pkg::MODE_COUNT, '1, '1);
        queue_request(plid_pkg::MODE_INSERT, 32'h1111_2222, 5'd1);
        queue_request(plid_pkg::MODE_INSERT, 32'hFFFF_FFFF, 5'd0);
        queue_request(plid_pkg::MODE_INSERT, 32'h0000_0000, 5'd1);
        queue_request(plid_pkg::MODE_INSERT, 32'hA5A5_5A5A, 5'd0);
        queue_request(plid_pkg::MODE_INSERT, 32'h1234_5678, 5'd2);
        queue_request(plid_pkg::MODE_INSERT, 32'h5A5A_A5A5, 5'd5);
        queue_request(plid_pkg::MODE_INSERT, 32'hDEAD_BEEF, plid_pkg::POS_W'(POS_MAX));
        queue_request(plid_pkg::MODE_COUNT, '0, '0);
        queue_request(plid_pkg::MODE_LIST_FWD, '0, '0);
        queue_request(plid_pkg::MODE_LIST_REV, '0, '0);
        queue_request(plid_pkg::MODE_DELETE, '0, 5'd4);
        queue_request(plid_pkg::MODE_DELETE, '0, plid_pkg::POS_W'(POS_MAX));
        queue_request(plid_pkg::MODE_DELETE, '0, 5'd1);
        queue_request(plid_pkg::MODE_DELETE, '0, 5'd0);
        queue_request(plid_pkg::MODE_DELETE, '0, 5'd1);
        queue_request(MODE_RESERVED_MIN, 32'hCAFE_F00D, 5'd0);
        queue_request(MODE_RESERVED_MID, '1, 5'd3);
        queue_request(MODE_RESERVED_MAX, '1, plid_pkg::POS_W'(POS_MAX));
        queue_request(plid_pkg::MODE_LIST_FWD, '0, '0);
        queue_request(plid_pkg::MODE_COUNT, '0, '0);
        wait_drained();

        // Fill to capacity, then push on a full list
        repeat (30) queue_random(70, 10);
        while (planned_len < CAPACITY)
            queue_request(plid_pkg::MODE_INSERT, pick_value(),
                          plid_pkg::POS_W'($urandom_range(0, planned_len)));
        queue_request(plid_pkg::MODE_INSERT, pick_value(),
                      plid_pkg::POS_W'($urandom_range(0, CAPACITY)));
        queue_request(plid_pkg::MODE_INSERT, pick_value(), plid_pkg::POS_W'(POS_MAX));

        // Long receiver hold while full read-outs and more requests pile up
        hold_requests++;
        queue_request(plid_pkg::MODE_LIST_FWD, '0, '0);
        queue_request(plid_pkg::MODE_LIST_REV, '0, '0);
        repeat (10) queue_random(35, 35);

        repeat (50) queue_random(40, 30);
        wait_drained();

        // Drain to empty, then hit the empty list
        repeat (25) queue_random(15, 60);
        while (planned_len != 0)
            queue_request(plid_pkg::MODE_DELETE, '0,
                          plid_pkg::POS_W'($urandom_range(0, planned_len - 1)));
        queue_request(plid_pkg::MODE_DELETE, '0, plid_pkg::POS_W'($urandom_range(0, POS_MAX)));
        queue_request(plid_pkg::MODE_LIST_REV, '0, '0);

        // Tail of the run at full rate on both sides
        quiet_tail = 1'b1;
        repeat (35) queue_random(40, 35);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("positional_list_insert_delete: match");
        end else begin
            $display("positional_list_insert_delete: mismatch");
        end
        $finish;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("positional_list_insert_delete: mismatch");
        $finish;
    end

endmodule

[sim.f]
rtl/plid_pkg.sv
rtl/plid_if.sv
rtl/plid_cell.sv
rtl/plid_chain.sv
rtl/positional_list_insert_delete.sv
bench/tb_top.sv
